// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/wdcalu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdcalu_pkg
// Operation codes, status bit masks and helper functions of the 65816-style
// accumulator, index and status core.
// ----------------------------------------------------------------------------
package wdcalu_pkg;

  typedef enum logic [3:0] {
    OP_ADC  = 4'd0,
    OP_SBC  = 4'd1,
    OP_INC  = 4'd2,
    OP_DEC  = 4'd3,
    OP_ASL  = 4'd4,
    OP_LSR  = 4'd5,
    OP_ROL  = 4'd6,
    OP_CMPA = 4'd7,
    OP_CMPX = 4'd8,
    OP_CMPY = 4'd9,
    OP_LDA  = 4'd10,
    OP_LDX  = 4'd11,
    OP_LDY  = 4'd12,
    OP_SETP = 4'd13
  } alu_op_t;

  localparam logic [7:0] FLAG_C = 8'h01;
  localparam logic [7:0] FLAG_Z = 8'h02;
  localparam logic [7:0] FLAG_X = 8'h10;
  localparam logic [7:0] FLAG_M = 8'h20;
  localparam logic [7:0] FLAG_V = 8'h40;
  localparam logic [7:0] FLAG_N = 8'h80;

  localparam logic [7:0] KEEP_NOT_NZ = 8'h7d;
  localparam logic [7:0] KEEP_NOT_C  = 8'hfe;
  localparam logic [7:0] KEEP_NOT_VC = 8'hbe;

  localparam logic [15:0] SIGN16    = 16'h8000;
  localparam logic [15:0] HIGH_BYTE = 16'hff00;

  // N and Z bits of a value at 8 or 16 bit width
  function automatic logic [7:0] nz_bits(input logic [15:0] v, input logic narrow);
    logic zero;
    logic neg;
    zero = narrow ? (v[7:0] == 8'h00) : (v == 16'h0000);
    neg  = narrow ? v[7] : ((v & SIGN16) != 16'h0000);
    return (zero ? FLAG_Z : 8'h00) | (neg ? FLAG_N : 8'h00);
  endfunction

  // accumulator write: 8-bit mode keeps the high byte
  function automatic logic [15:0] acc_write(input logic [15:0] a, input logic [15:0] v,
                                            input logic narrow);
    return narrow ? ((a & HIGH_BYTE) | {8'h00, v[7:0]}) : v;
  endfunction

endpackage

// ----- rtl/wdc65816_alu_flags.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdc65816_alu_flags
// Binary-mode accumulator, index and status core of a 65816-style processor.
// Each item (cmd, operand) runs one operation on A, X, Y and P and returns
// all four registers afterwards. Items go into an input register and are
// executed from there into the architectural registers, which drive the
// result ports directly. The block sustains one item per clock while the
// output side is not stalled; a result is offered after its item has moved
// through the input register into the architectural registers. The rate is
// set by the loop from A/X/Y/P through the 17-bit adder and flag logic back.
// ----------------------------------------------------------------------------
module wdc65816_alu_flags (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  cmd,
  input  logic [15:0] operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] acc_out,
  output logic [15:0] x_out,
  output logic [15:0] y_out,
  output logic [7:0]  flags_out
);

  logic        in_full;
  logic [3:0]  cmd_q;
  logic [15:0] op_q;
  logic        advance;

  logic [15:0] acc;
  logic [15:0] idx_x;
  logic [15:0] idx_y;
  logic [7:0]  stat;
  logic [15:0] acc_next;
  logic [15:0] idx_x_next;
  logic [15:0] idx_y_next;
  logic [7:0]  stat_next;

  // execute when the result register is free or being emptied
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      cmd_q <= cmd;
      op_q  <= operand;
    end
  end

  // datapath
  logic        m_narrow;
  logic        x_narrow;
  logic        c_in;
  logic [15:0] a_w;
  logic [15:0] op_w;
  logic [15:0] rhs_w;
  logic [16:0] sum;
  logic        add_c;
  logic        add_v;
  logic        cmp_narrow;
  logic [15:0] cmp_reg;
  logic [16:0] diff;
  logic [15:0] mod_res;
  logic [15:0] acc_mod;
  logic [15:0] acc_add;
  logic [15:0] acc_ld;
  logic [15:0] idx_ld;
  logic        shift_c;

  function automatic logic alu_op_is_sub(input logic [3:0] c);
    return c == wdcalu_pkg::OP_SBC;
  endfunction

  always_comb begin
    m_narrow = (stat & wdcalu_pkg::FLAG_M) != 8'h00;
    x_narrow = (stat & wdcalu_pkg::FLAG_X) != 8'h00;
    c_in     = (stat & wdcalu_pkg::FLAG_C) != 8'h00;

    a_w   = m_narrow ? {8'h00, acc[7:0]} : acc;
    op_w  = (alu_op_is_sub(cmd_q)) ? ~op_q : op_q;
    rhs_w = m_narrow ? {8'h00, op_w[7:0]} : op_w;
    sum   = {1'b0, a_w} + {1'b0, rhs_w} + {16'h0000, c_in};
    add_c = m_narrow ? sum[8] : sum[16];
    add_v = m_narrow ? (~(a_w[7] ^ rhs_w[7]) & (a_w[7] ^ sum[7]))
                     : (~(a_w[15] ^ rhs_w[15]) & (a_w[15] ^ sum[15]));
    acc_add = wdcalu_pkg::acc_write(acc, sum[15:0], m_narrow);

    // compares share one subtractor
    cmp_narrow = (cmd_q == wdcalu_pkg::OP_CMPA) ? m_narrow : x_narrow;
    case (cmd_q)
      wdcalu_pkg::OP_CMPX: cmp_reg = idx_x;
      wdcalu_pkg::OP_CMPY: cmp_reg = idx_y;
      default:             cmp_reg = acc;
    endcase
    if (cmp_narrow) begin
      diff = {9'h000, cmp_reg[7:0]} - {9'h000, op_q[7:0]};
    end else begin
      diff = {1'b0, cmp_reg} - {1'b0, op_q};
    end

    case (cmd_q)
      wdcalu_pkg::OP_INC: mod_res = acc + 16'h0001;
      wdcalu_pkg::OP_DEC: mod_res = acc - 16'h0001;
      wdcalu_pkg::OP_ASL: mod_res = {acc[14:0], 1'b0};
      wdcalu_pkg::OP_LSR: mod_res = {1'b0, a_w[15:1]};
      default:            mod_res = {acc[14:0], c_in};
    endcase
    acc_mod = wdcalu_pkg::acc_write(acc, mod_res, m_narrow);
    shift_c = (cmd_q == wdcalu_pkg::OP_LSR) ? acc[0]
                                            : (m_narrow ? acc[7] : acc[15]);

    acc_ld = wdcalu_pkg::acc_write(acc, op_q, m_narrow);
    idx_ld = x_narrow ? {8'h00, op_q[7:0]} : op_q;

    acc_next   = acc;
    idx_x_next = idx_x;
    idx_y_next = idx_y;
    stat_next  = stat;

    case (cmd_q)
      wdcalu_pkg::OP_ADC, wdcalu_pkg::OP_SBC: begin
        acc_next  = acc_add;
        stat_next = (stat & wdcalu_pkg::KEEP_NOT_NZ & wdcalu_pkg::KEEP_NOT_VC)
                  | wdcalu_pkg::nz_bits(acc_add, m_narrow)
                  | (add_v ? wdcalu_pkg::FLAG_V : 8'h00)
                  | (add_c ? wdcalu_pkg::FLAG_C : 8'h00);
      end
      wdcalu_pkg::OP_INC, wdcalu_pkg::OP_DEC: begin
        acc_next  = acc_mod;
        stat_next = (stat & wdcalu_pkg::KEEP_NOT_NZ) | wdcalu_pkg::nz_bits(acc_mod, m_narrow);
      end
      wdcalu_pkg::OP_ASL, wdcalu_pkg::OP_LSR, wdcalu_pkg::OP_ROL: begin
        acc_next  = acc_mod;
        stat_next = (stat & wdcalu_pkg::KEEP_NOT_NZ & wdcalu_pkg::KEEP_NOT_C)
                  | wdcalu_pkg::nz_bits(acc_mod, m_narrow)
                  | (shift_c ? wdcalu_pkg::FLAG_C : 8'h00);
      end
      wdcalu_pkg::OP_CMPA, wdcalu_pkg::OP_CMPX, wdcalu_pkg::OP_CMPY: begin
        // no borrow means reg >= operand
        stat_next = (stat & wdcalu_pkg::KEEP_NOT_NZ & wdcalu_pkg::KEEP_NOT_C)
                  | wdcalu_pkg::nz_bits(diff[15:0], cmp_narrow)
                  | (diff[16] ? 8'h00 : wdcalu_pkg::FLAG_C);
      end
      wdcalu_pkg::OP_LDA: begin
        acc_next  = acc_ld;
        stat_next = (stat & wdcalu_pkg::KEEP_NOT_NZ) | wdcalu_pkg::nz_bits(acc_ld, m_narrow);
      end
      wdcalu_pkg::OP_LDX: begin
        idx_x_next = idx_ld;
        stat_next  = (stat & wdcalu_pkg::KEEP_NOT_NZ) | wdcalu_pkg::nz_bits(idx_ld, x_narrow);
      end
      wdcalu_pkg::OP_LDY: begin
        idx_y_next = idx_ld;
        stat_next  = (stat & wdcalu_pkg::KEEP_NOT_NZ) | wdcalu_pkg::nz_bits(idx_ld, x_narrow);
      end
      wdcalu_pkg::OP_SETP: begin
        stat_next = op_q[7:0];
        // 8-bit index mode drops the index high bytes
        if ((op_q[7:0] & wdcalu_pkg::FLAG_X) != 8'h00) begin
          idx_x_next = {8'h00, idx_x[7:0]};
          idx_y_next = {8'h00, idx_y[7:0]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 16'h0000;
      idx_x     <= 16'h0000;
      idx_y     <= 16'h0000;
      stat      <= 8'h00;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        acc   <= acc_next;
        idx_x <= idx_x_next;
        idx_y <= idx_y_next;
        stat  <= stat_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // the registers themselves hold the result until the next item executes
  assign acc_out   = acc;
  assign x_out     = idx_x;
  assign y_out     = idx_y;
  assign flags_out = stat;

endmodule

// ----- rtl/wdcalu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdcalu_checker
// Port-level checks of the accumulator, index and status core, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wdcalu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] acc_out,
  input logic [15:0] x_out,
  input logic [15:0] y_out,
  input logic [7:0]  flags_out
);

  // no item is in flight right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

  // an empty result register never back-pressures the input
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst, !out_valid, in_ready)

  // 8-bit index mode leaves no high byte in X or Y
  `ASSERT_IMPLY(a_index_narrow, clk, rst, (flags_out & wdcalu_pkg::FLAG_X) != 8'h00, (x_out[15:8] == 8'h00) && (y_out[15:8] == 8'h00))

  // a stalled result holds every register
  `ASSERT_NEXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(acc_out) && $stable(x_out) && $stable(y_out) && $stable(flags_out))

endmodule

bind wdc65816_alu_flags wdcalu_checker u_wdcalu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .acc_out   (acc_out),
  .x_out     (x_out),
  .y_out     (y_out),
  .flags_out (flags_out)
);
